[sv/assert_macros.svh]
// assertion macros for the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is low
`define BRHP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked assertion that stays active during reset
`define BRHP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[sv/brhp_pkg.sv]
// shared types, codes and constants of the byte range header parser
`default_nettype none

package brhp_pkg;

    localparam int BYTE_W       = 8;
    localparam int FS_W         = 48;
    localparam int END_W        = 49;
    localparam int CODE_W       = 3;
    localparam int DEF_POS_BITS = 48;
    localparam int PREFIX_LEN   = 6;

    localparam logic [2:0] BC_SAT     = 3'd7;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    // number field scan state
    typedef enum logic [4:0] {
        SCAN_EMPTY  = 5'b00001,
        SCAN_WS     = 5'b00010,
        SCAN_SIGN   = 5'b00100,
        SCAN_DIGITS = 5'b01000,
        SCAN_BAD    = 5'b10000
    } t_scan;

    // result codes
    typedef enum logic [CODE_W-1:0] {
        ERR_OK       = 3'd0,
        ERR_PREFIX   = 3'd1,
        ERR_NO_DASH  = 3'd2,
        ERR_START    = 3'd3,
        ERR_END      = 3'd4,
        ERR_ORDER    = 3'd5,
        ERR_SUFFIX   = 3'd6,
        ERR_PAST_EOF = 3'd7
    } t_err;

    // expected byte of the "bytes=" prefix at a given position
    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h62; // b
            3'd1:    c = 8'h79; // y
            3'd2:    c = 8'h74; // t
            3'd3:    c = 8'h65; // e
            3'd4:    c = 8'h73; // s
            3'd5:    c = 8'h3D; // =
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[sv/byte_range_header_parser.sv]
// byte range header parser: scans a Range header value and resolves it
//
// Input channel: one header byte per item (i_header_byte), i_is_final marks
// the last byte. An item is taken when i_in_valid is high and o_in_stall low.
// Output channel: one result item per final byte (range_valid, error_code,
// range_start, range_end), taken when o_out_valid is high and i_out_stall low.
// Config channel: i_file_size is written when i_cfg_valid is high; o_cfg_ready
// is always high. Write it only while no header is in flight.
// Throughput: one byte per cycle while o_in_stall is low. Each byte updates
// the scan state in the cycle it is taken (a times-ten add and a saturation
// compare bound that path). The snapshot stage latches a final byte's scan
// state; it is then resolved against the file size into the output register
// that drives o_out_valid.
// Reset (synchronous, active low) clears the scan state, file size and both
// valid stages. When the receiver stalls the result holds; the snapshot stage
// still takes one more final byte, and only then o_in_stall rises.
`default_nettype none

module byte_range_header_parser #(
    parameter int POS_BITS = brhp_pkg::DEF_POS_BITS
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // config
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire  [brhp_pkg::FS_W-1:0]    i_file_size,
    // input items
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire  [brhp_pkg::BYTE_W-1:0]  i_header_byte,
    input  wire                          i_is_final,
    // result items
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic                         o_range_valid,
    output logic [brhp_pkg::CODE_W-1:0]  o_error_code,
    output logic [brhp_pkg::FS_W-1:0]    o_range_start,
    output logic signed [brhp_pkg::END_W-1:0] o_range_end
);
    import brhp_pkg::*;

    localparam int W    = (POS_BITS > FS_W) ? POS_BITS : FS_W;
    localparam int ACCW = POS_BITS + 4;
    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    typedef struct packed {
        t_scan               scan;
        logic [POS_BITS-1:0] val;
        logic                neg;
    } t_field;

    // one byte of number syntax: whitespace, sign, digits, saturating value
    function automatic t_field feed_field(input logic [7:0] c, input t_field f);
        t_field          r;
        logic            digit;
        logic            ws;
        logic [ACCW-1:0] acc;
        r     = f;
        digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        ws    = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
        unique case (f.scan)
            SCAN_EMPTY, SCAN_WS: begin
                if (ws) begin
                    r.scan = SCAN_WS;
                end else if ((c == CHAR_PLUS) || (c == CHAR_DASH)) begin
                    r.scan = SCAN_SIGN;
                    r.neg  = (c == CHAR_DASH);
                end else if (digit) begin
                    r.scan = SCAN_DIGITS;
                end else begin
                    r.scan = SCAN_BAD;
                end
            end
            SCAN_SIGN, SCAN_DIGITS: r.scan = digit ? SCAN_DIGITS : SCAN_BAD;
            default:                r.scan = SCAN_BAD;
        endcase
        // value * 10 + digit, saturating at the top of the field width
        acc = (ACCW'(f.val) << 3) + (ACCW'(f.val) << 1) + ACCW'(c - CHAR_ZERO);
        if (digit && (r.scan == SCAN_DIGITS)) begin
            r.val = (acc > ACCW'(POS_MAX)) ? POS_MAX : acc[POS_BITS-1:0];
        end
        return r;
    endfunction

    // scan state
    logic [2:0]    r_byte_count, n_byte_count;
    logic          r_prefix_match, n_prefix_match;
    logic          r_dash_seen, n_dash_seen;
    t_field        r_start, n_start;
    t_field        r_end, n_end;
    logic [FS_W-1:0] r_file_size;

    // snapshot stage
    logic          r_snap_vld, n_snap_vld;
    logic          r_s_bc_full, r_s_prefix, r_s_dash;
    t_field        r_s_start, r_s_end;

    // output register
    logic          r_out_vld;
    logic          r_range_valid;
    t_err          r_error_code;
    logic [FS_W-1:0] r_range_start;
    logic signed [END_W-1:0] r_range_end;

    logic   in_acc;
    logic   snap_adv;
    t_field fed;
    t_field field_clear;

    assign snap_adv    = !r_out_vld || !i_out_stall;
    assign o_in_stall  = r_snap_vld && !snap_adv;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign field_clear = '{scan: SCAN_EMPTY, val: '0, neg: 1'b0};

    // per-byte scan update
    always_comb begin
        n_byte_count   = r_byte_count;
        n_prefix_match = r_prefix_match;
        n_dash_seen    = r_dash_seen;
        n_start        = r_start;
        n_end          = r_end;
        fed            = feed_field(i_header_byte, r_dash_seen ? r_end : r_start);
        if (in_acc) begin
            if (r_byte_count < 3'(PREFIX_LEN)) begin
                if (i_header_byte != prefix_char(r_byte_count)) begin
                    n_prefix_match = 1'b0;
                end
            end else if (!r_dash_seen) begin
                if (i_header_byte == CHAR_DASH) begin
                    n_dash_seen = 1'b1;
                end else begin
                    n_start = fed;
                end
            end else begin
                n_end = fed;
            end
            if (r_byte_count != BC_SAT) begin
                n_byte_count = r_byte_count + 3'd1;
            end
        end
    end

    // snapshot valid
    always_comb begin
        n_snap_vld = r_snap_vld;
        if (in_acc && i_is_final) begin
            n_snap_vld = 1'b1;
        end else if (snap_adv) begin
            n_snap_vld = 1'b0;
        end
    end

    // scan state and config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count   <= '0;
            r_prefix_match <= 1'b1;
            r_dash_seen    <= 1'b0;
            r_start        <= field_clear;
            r_end          <= field_clear;
            r_file_size    <= '0;
            r_snap_vld     <= 1'b0;
        end else begin
            r_snap_vld <= n_snap_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                r_file_size <= i_file_size;
            end
            if (in_acc && i_is_final) begin
                r_byte_count   <= '0;
                r_prefix_match <= 1'b1;
                r_dash_seen    <= 1'b0;
                r_start        <= field_clear;
                r_end          <= field_clear;
            end else begin
                r_byte_count   <= n_byte_count;
                r_prefix_match <= n_prefix_match;
                r_dash_seen    <= n_dash_seen;
                r_start        <= n_start;
                r_end          <= n_end;
            end
        end
    end

    // snapshot payload of a finished header
    always_ff @(posedge i_clk) begin
        if (in_acc && i_is_final) begin
            r_s_bc_full <= (n_byte_count == BC_SAT);
            r_s_prefix  <= n_prefix_match;
            r_s_dash    <= n_dash_seen;
            r_s_start   <= n_start;
            r_s_end     <= n_end;
        end
    end

    // resolve against the file size
    logic                    s_pres, e_pres;
    logic [W-1:0]            sv, ev, fs, sfx_diff;
    logic signed [END_W-1:0] fs_m1;
    t_err                    res_code;
    logic [FS_W-1:0]         res_start;
    logic signed [END_W-1:0] res_end;

    always_comb begin
        s_pres    = (r_s_start.scan != SCAN_EMPTY);
        e_pres    = (r_s_end.scan != SCAN_EMPTY);
        sv        = W'(r_s_start.val);
        ev        = W'(r_s_end.val);
        fs        = W'(r_file_size);
        sfx_diff  = fs - ev;
        fs_m1     = $signed({1'b0, r_file_size}) - END_W'(1);
        res_code  = ERR_OK;
        res_start = '0;
        res_end   = '0;
        priority if (!r_s_bc_full || !r_s_prefix) begin
            res_code = ERR_PREFIX;
        end else if (!r_s_dash) begin
            res_code = ERR_NO_DASH;
        end else if (s_pres && (r_s_start.scan != SCAN_DIGITS)) begin
            res_code = ERR_START;
        end else if (e_pres && (r_s_end.scan != SCAN_DIGITS)) begin
            res_code = ERR_END;
        end else if (s_pres && e_pres &&
                     ((r_s_end.neg && (ev != '0)) || (sv > ev))) begin
            res_code = ERR_ORDER;
        end else if (!s_pres && e_pres) begin
            // suffix form: last N bytes
            if (r_s_end.neg || (ev == '0) || (ev > fs)) begin
                res_code = ERR_SUFFIX;
            end else begin
                res_start = sfx_diff[FS_W-1:0];
                res_end   = fs_m1;
            end
        end else if (s_pres && (sv >= fs)) begin
            res_code = ERR_PAST_EOF;
        end else begin
            // explicit or open end, clamped to the last byte
            res_start = s_pres ? sv[FS_W-1:0] : '0;
            if (e_pres && (ev < fs)) begin
                res_end = $signed({1'b0, ev[FS_W-1:0]});
            end else begin
                res_end = fs_m1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (snap_adv) begin
            r_out_vld <= r_snap_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (snap_adv && r_snap_vld) begin
            r_range_valid <= (res_code == ERR_OK);
            r_error_code  <= res_code;
            r_range_start <= res_start;
            r_range_end   <= res_end;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_range_valid = r_range_valid;
    assign o_error_code  = r_error_code;
    assign o_range_start = r_range_start;
    assign o_range_end   = r_range_end;

endmodule

`default_nettype wire

[sv/brhp_checker.sv]
// port-level checks for the byte range header parser, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module brhp_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          o_in_stall,
    input wire                          o_out_valid,
    input wire                          i_out_stall,
    input wire                          o_range_valid,
    input wire [brhp_pkg::CODE_W-1:0]   o_error_code,
    input wire [brhp_pkg::FS_W-1:0]     o_range_start,
    input wire [brhp_pkg::END_W-1:0]    o_range_end
);
    import brhp_pkg::*;

    // valid flag agrees with the result code
    `BRHP_ASSERT(a_valid_code, i_clk, i_rst_n, o_out_valid |-> (o_range_valid == (o_error_code == ERR_OK)), "range_valid disagrees with error_code")

    // a failed range carries zero offsets
    `BRHP_ASSERT(a_err_zero, i_clk, i_rst_n, (o_out_valid && !o_range_valid) |-> ((o_range_start == '0) && (o_range_end == '0)), "invalid result with nonzero offsets")

    // a good range is ordered; a negative end only for the empty open range
    `BRHP_ASSERT(a_range_order, i_clk, i_rst_n, (o_out_valid && o_range_valid) |-> (o_range_end[END_W-1] ? ((o_range_start == '0) && (o_range_end == '1)) : (o_range_start <= o_range_end[FS_W-1:0])), "resolved range out of order")

    // input backs up only behind a stalled result
    `BRHP_ASSERT_ALWAYS(a_stall_cause, i_clk, o_in_stall |-> (o_out_valid && i_out_stall), "input stalled without a stalled result")

    // a stalled result holds
    `BRHP_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_error_code) && $stable(o_range_start) && $stable(o_range_end)), "stalled result changed")

endmodule

bind byte_range_header_parser brhp_checker u_brhp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_range_valid (o_range_valid),
    .o_error_code  (o_error_code),
    .o_range_start (o_range_start),
    .o_range_end   (o_range_end)
);

`default_nettype wire

[dv/tb.sv]
// testbench for the byte range header parser: directed and random headers checked by a predictor
`timescale 1ns / 100ps

module tb;
    import brhp_pkg::*;

    localparam int POS_BITS       = DEF_POS_BITS;
    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 6;
    localparam int IDLE_PCT       = 33;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASES         = 8;
    localparam int HDRS_PER_PHASE = 6;
    localparam int NOISE_BYTES    = 150;

    localparam logic [8*PREFIX_LEN-1:0] UNIT_TEXT = "bytes=";
    localparam logic [BYTE_W-1:0] CHAR_VT  = 8'h0B;
    localparam logic [BYTE_W-1:0] CHAR_FF  = 8'h0C;
    localparam logic [BYTE_W-1:0] CHAR_NUL = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_TOP = 8'hFF;
    localparam logic [FS_W-1:0]   FS_TOP   = {FS_W{1'b1}};
    localparam logic [FS_W-1:0]   FS_HIGH  = FS_TOP - 1'b1;
    localparam logic [FS_W-1:0]   FS_MID   = 48'd1000;

    typedef struct packed {
        logic              range_valid;
        t_err              error_code;
        logic [FS_W-1:0]   range_start;
        logic [END_W-1:0]  range_end;
    } t_range_result;

    // dut ports
    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     i_cfg_valid   = 1'b0;
    logic [FS_W-1:0]          i_file_size   = '0;
    logic                     i_in_valid    = 1'b0;
    logic [BYTE_W-1:0]        i_header_byte = '0;
    logic                     i_is_final    = 1'b0;
    logic                     i_out_stall   = 1'b0;
    logic                     o_cfg_ready;
    logic                     o_in_stall;
    logic                     o_out_valid;
    logic                     o_range_valid;
    logic [CODE_W-1:0]        o_error_code;
    logic [FS_W-1:0]          o_range_start;
    logic signed [END_W-1:0]  o_range_end;

    // predictor state
    logic [FS_W-1:0]   pred_file_size  = '0;
    logic [2:0]        pred_count      = '0;
    logic              pred_unit_ok    = 1'b1;
    logic              pred_dash       = 1'b0;
    logic [63:0]       pred_first      = '0;
    t_scan             pred_first_scan = SCAN_EMPTY;
    logic [63:0]       pred_last       = '0;
    t_scan             pred_last_scan  = SCAN_EMPTY;
    logic              pred_last_neg   = 1'b0;
    t_range_result     ranges_due[$];
    t_range_result     range_want;

    // stimulus and bookkeeping
    logic [BYTE_W-1:0] hdr_bytes[$];
    bit                no_idle      = 1'b0;
    int unsigned       hold_req_cnt = 0;
    int unsigned       hold_ack_cnt = 0;
    int                hold_left    = 0;
    int unsigned       mismatch_cnt = 0;
    int                stuck_cycles = 0;

    byte_range_header_parser #(
        .POS_BITS(POS_BITS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_file_size   (i_file_size),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_header_byte (i_header_byte),
        .i_is_final    (i_is_final),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_range_valid (o_range_valid),
        .o_error_code  (o_error_code),
        .o_range_start (o_range_start),
        .o_range_end   (o_range_end)
    );

    // clock
    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic logic is_blank(input logic [BYTE_W-1:0] c);
        return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    // one byte of a decimal field: whitespace, optional sign, digits
    function automatic void scan_number_byte(input logic [BYTE_W-1:0] c, inout t_scan scan,
                                             inout logic [63:0] mag, inout logic neg);
        logic        digit;
        logic [63:0] d;
        logic [63:0] top;
        digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        d     = {56'd0, c - CHAR_ZERO};
        top   = (64'd1 << POS_BITS) - 64'd1;
        case (scan)
            SCAN_EMPTY, SCAN_WS: begin
                if (is_blank(c)) begin
                    scan = SCAN_WS;
                end else if (c == CHAR_PLUS || c == CHAR_DASH) begin
                    scan = SCAN_SIGN;
                    neg  = (c == CHAR_DASH);
                end else if (digit) begin
                    scan = SCAN_DIGITS;
                end else begin
                    scan = SCAN_BAD;
                end
            end
            SCAN_SIGN, SCAN_DIGITS: scan = digit ? SCAN_DIGITS : SCAN_BAD;
            default: scan = SCAN_BAD;
        endcase
        // saturating times-ten accumulate
        if (digit && scan == SCAN_DIGITS) begin
            if (mag > (top - d) / 64'd10) begin
                mag = top;
            end else begin
                mag = mag * 64'd10 + d;
            end
        end
    endfunction

    // accepted header byte: update scan state, resolve on the final byte
    function automatic void take_header_byte(input logic [BYTE_W-1:0] c, input logic fin);
        logic          dummy_neg;
        logic          s_here;
        logic          e_here;
        longint        size_m1;
        longint        last_end;
        logic [63:0]   start_pos;
        t_err          code;
        t_range_result res;
        dummy_neg = 1'b0;
        if (pred_count < PREFIX_LEN) begin
            if (c != UNIT_TEXT[8 * (PREFIX_LEN - 1 - int'(pred_count)) +: 8]) begin
                pred_unit_ok = 1'b0;
            end
        end else if (!pred_dash) begin
            if (c == CHAR_DASH) begin
                pred_dash = 1'b1;
            end else begin
                scan_number_byte(c, pred_first_scan, pred_first, dummy_neg);
            end
        end else begin
            scan_number_byte(c, pred_last_scan, pred_last, pred_last_neg);
        end
        if (pred_count < BC_SAT) begin
            pred_count++;
        end
        if (!fin) begin
            return;
        end

        // resolve against the file size, errors in priority order
        code      = ERR_OK;
        start_pos = '0;
        last_end  = 0;
        s_here    = pred_first_scan != SCAN_EMPTY;
        e_here    = pred_last_scan != SCAN_EMPTY;
        size_m1   = longint'(pred_file_size) - 1;
        if (pred_count < BC_SAT || !pred_unit_ok) begin
            code = ERR_PREFIX;
        end else if (!pred_dash) begin
            code = ERR_NO_DASH;
        end else if (s_here && pred_first_scan != SCAN_DIGITS) begin
            code = ERR_START;
        end else if (e_here && pred_last_scan != SCAN_DIGITS) begin
            code = ERR_END;
        end else if (s_here && e_here &&
                     ((pred_last_neg && pred_last != 0) || pred_first > pred_last)) begin
            code = ERR_ORDER;
        end else if (!s_here && e_here) begin
            // suffix form: last n bytes
            if (pred_last_neg || pred_last == 0 || pred_last > pred_file_size) begin
                code = ERR_SUFFIX;
            end else begin
                start_pos = pred_file_size - pred_last;
                last_end  = size_m1;
            end
        end else if (s_here && pred_first >= pred_file_size) begin
            code = ERR_PAST_EOF;
        end else begin
            // open or explicit end, clamped to the last byte
            start_pos = s_here ? pred_first : 64'd0;
            last_end  = size_m1;
            if (e_here && longint'(pred_last) < size_m1) begin
                last_end = longint'(pred_last);
            end
        end

        res.range_valid = (code == ERR_OK);
        res.error_code  = code;
        res.range_start = (code == ERR_OK) ? start_pos[FS_W-1:0] : '0;
        res.range_end   = (code == ERR_OK) ? last_end[END_W-1:0] : '0;
        ranges_due.push_back(res);

        // back to the start of a header
        pred_count      = '0;
        pred_unit_ok    = 1'b1;
        pred_dash       = 1'b0;
        pred_first      = '0;
        pred_first_scan = SCAN_EMPTY;
        pred_last       = '0;
        pred_last_scan  = SCAN_EMPTY;
        pred_last_neg   = 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    function automatic void flag_mismatch(input string what, input logic [63:0] want,
                                          input logic [63:0] got);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS) begin
            $display("mismatch in %0s at %0t: expected %0h, got %0h", what, $time, want, got);
        end
    endfunction

    // compare each accepted result item with the oldest expected one
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (ranges_due.size() == 0) begin
                flag_mismatch("result with none expected", '0, o_error_code);
            end else begin
                range_want = ranges_due.pop_front();
                if (o_range_valid !== range_want.range_valid) begin
                    flag_mismatch("range_valid", range_want.range_valid, o_range_valid);
                end
                if (o_error_code !== range_want.error_code) begin
                    flag_mismatch("error_code", range_want.error_code, o_error_code);
                end
                if (o_range_start !== range_want.range_start) begin
                    flag_mismatch("range_start", range_want.range_start, o_range_start);
                end
                if (o_range_end !== range_want.range_end) begin
                    flag_mismatch("range_end", range_want.range_end, o_range_end);
                end
            end
        end
    end

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left   <= 0;
        end else if (hold_ack_cnt != hold_req_cnt) begin
            hold_ack_cnt <= hold_req_cnt;
            hold_left    <= HOLD_CYCLES;
            i_out_stall  <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("byte_range_header_parser regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // offer one header byte, with random idle cycles ahead of it
    task automatic send_header_byte(input logic [BYTE_W-1:0] c, input logic fin);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_header_byte <= c;
        i_is_final    <= fin;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        take_header_byte(c, fin);
    endtask

    // send the assembled header, final flag on its last byte
    task automatic send_header();
        foreach (hdr_bytes[k]) begin
            send_header_byte(hdr_bytes[k], k == hdr_bytes.size() - 1);
        end
        hdr_bytes.delete();
    endtask

    // wait until every expected result is back and the pipeline is empty
    task automatic wait_for_idle();
        i_in_valid <= 1'b0;
        while (ranges_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_file_size(input logic [FS_W-1:0] size);
        wait_for_idle();
        i_cfg_valid <= 1'b1;
        i_file_size <= size;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid    <= 1'b0;
        pred_file_size = size;
    endtask

    // ------------------------------------------------------------------
    // header builders
    // ------------------------------------------------------------------

    function automatic void put_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            hdr_bytes.push_back(s[k]);
        end
    endfunction

    function automatic void put_number(input longint unsigned v);
        put_text($sformatf("%0d", v));
    endfunction

    function automatic void put_blanks();
        repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 5) == 0) begin
                hdr_bytes.push_back(CHAR_SPACE);
            end else begin
                hdr_bytes.push_back(CHAR_TAB + 8'($urandom_range(0, 4)));
            end
        end
    endfunction

    // digit run of 15 to 22 digits, mostly long enough to saturate the accumulator
    function automatic void put_long_digits();
        hdr_bytes.push_back(CHAR_ZERO + 8'($urandom_range(1, 9)));
        repeat ($urandom_range(14, 21)) begin
            hdr_bytes.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
    endfunction

    function automatic logic [BYTE_W-1:0] junk_byte();
        logic [BYTE_W-1:0] j;
        do begin
            j = 8'($urandom_range(0, 255));
        end while (j >= CHAR_ZERO && j <= CHAR_NINE);
        return j;
    endfunction

    // values around the file size, plus wide ones of varied magnitude
    function automatic longint unsigned pick_value(input longint unsigned near);
        case ($urandom_range(0, 5))
            0: return 0;
            1: return (near == 0) ? 0 : near - 1;
            2: return near;
            3: return near + 1;
            4: return (near > 50) ? near - $urandom_range(0, 50) : $urandom_range(0, 60);
            default: return {$urandom, $urandom} >> $urandom_range(16, 63);
        endcase
    endfunction

    // one number field: mostly well formed, sometimes broken
    function automatic void put_field(input bit allow_minus, input longint unsigned near);
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            return;
        end
        if (kind >= 70 && kind < 80) begin
            put_blanks();
        end
        if (kind >= 75 && kind < 90) begin
            hdr_bytes.push_back((allow_minus && $urandom_range(0, 1)) ? CHAR_DASH : CHAR_PLUS);
        end
        if (kind >= 90 && kind < 95) begin
            put_long_digits();
        end else if (kind >= 95) begin
            case ($urandom_range(0, 2))
                0: begin
                    put_number(pick_value(near));
                    hdr_bytes.push_back(junk_byte());
                    if ($urandom_range(0, 1)) put_number($urandom_range(0, 99));
                end
                1: begin
                    if ($urandom_range(0, 1)) put_blanks();
                    else hdr_bytes.push_back(CHAR_PLUS);
                end
                default: begin
                    hdr_bytes.push_back(junk_byte());
                    put_number(pick_value(near));
                end
            endcase
        end else begin
            put_number(pick_value(near));
        end
    endfunction

    // one whole header value, mostly well formed
    function automatic void build_header(input logic [FS_W-1:0] size);
        int form;
        int cut;
        form = $urandom_range(0, 99);
        if (form < 4) begin
            // cut short inside the unit or right after it
            cut = $urandom_range(1, PREFIX_LEN);
            for (int k = 0; k < cut; k++) begin
                hdr_bytes.push_back(UNIT_TEXT[8 * (PREFIX_LEN - 1 - k) +: 8]);
            end
            return;
        end
        put_text("bytes=");
        if (form < 9) begin
            cut = $urandom_range(0, PREFIX_LEN - 1);
            hdr_bytes[cut] = hdr_bytes[cut] ^ 8'($urandom_range(1, 255));
        end
        put_field(1'b0, $urandom_range(0, 1) ? size : size / 2);
        if (form >= 9 && form < 13) begin
            return;
        end
        hdr_bytes.push_back(CHAR_DASH);
        put_field(1'b1, size);
        // a second dash lands in the end field
        if (form >= 13 && form < 16) begin
            hdr_bytes.push_back(CHAR_DASH);
            put_number($urandom_range(0, 999));
        end
    endfunction

    task automatic send_text(input string s);
        put_text(s);
        send_header();
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // unit prefix, header length and byte extremes
    task automatic test_prefix_rules();
        write_file_size(FS_MID);
        send_text("b");
        send_text("bytes=");
        send_text("Bytes=0-9");
        send_text("bytes:0-9");
        put_text("bytes=");
        hdr_bytes.push_back(CHAR_TOP);
        send_header();
        put_text("bytes=1-");
        hdr_bytes.push_back(CHAR_NUL);
        send_header();
    endtask

    // number syntax, dash split and range resolution on a mid-size file
    task automatic test_number_syntax();
        send_text("bytes=0-99");
        send_text("bytes=500-");
        send_text("bytes=-300");
        send_text("bytes=-");
        put_text("bytes=");
        hdr_bytes.push_back(CHAR_VT);
        put_text(" \t+7-");
        hdr_bytes.push_back(CHAR_FF);
        put_text("\r\n12");
        send_header();
        send_text("bytes=5");
        send_text("bytes=1a-2");
        send_text("bytes=+-5");
        send_text("bytes=1-2x");
        send_text("bytes=9-3");
        send_text("bytes=1--5");
        send_text("bytes=0--0");
        send_text("bytes=--5");
        send_text("bytes=-0");
        send_text("bytes=-2000");
        send_text("bytes=1000-");
        send_text("bytes=5-99999");
        send_text("bytes=1-2-3");
        send_text("bytes=99999999999999999999-");
    endtask

    // empty file and the largest file sizes
    task automatic test_file_size_edges();
        write_file_size('0);
        send_text("bytes=-");
        send_text("bytes=0-");
        write_file_size(FS_HIGH);
        send_text("bytes=99999999999999999999-");
        send_text("bytes=-99999999999999999999");
        send_text("bytes=0-");
        write_file_size(FS_TOP);
        send_text("bytes=-99999999999999999999");
        send_text("bytes=281474976710654-");
    endtask

    // random headers over several file sizes, one phase without idling
    task automatic test_random_headers();
        logic [FS_W-1:0] size;
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: size = '0;
                1: size = 48'd1;
                2: size = FS_HIGH;
                3: size = FS_TOP;
                5: size = FS_W'({$urandom, $urandom} >> $urandom_range(16, 40));
                6: size = FS_W'({$urandom, $urandom});
                default: size = FS_W'($urandom_range(2, 5000));
            endcase
            write_file_size(size);
            no_idle = (phase == 5);
            repeat (HDRS_PER_PHASE) begin
                build_header(size);
                send_header();
            end
        end
        no_idle = 1'b0;
    endtask

    // receiver holds off while headers keep coming, so the input must stall
    task automatic test_output_hold_off();
        write_file_size(FS_MID);
        hold_req_cnt++;
        repeat (12) begin
            build_header(FS_MID);
            send_header();
        end
    endtask

    // arbitrary bytes with random final flags
    task automatic test_random_bytes();
        for (int k = 0; k < NOISE_BYTES; k++) begin
            hdr_bytes.push_back(8'($urandom_range(0, 255)));
            if (k == NOISE_BYTES - 1 || $urandom_range(0, 5) == 0) begin
                send_header();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // run
    // ------------------------------------------------------------------

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_prefix_rules();
        test_number_syntax();
        test_file_size_edges();
        test_random_headers();
        test_output_hold_off();
        test_random_bytes();

        wait_for_idle();
        if (mismatch_cnt == 0 && ranges_due.size() == 0) begin
            $display("byte_range_header_parser regression: pass");
        end else begin
            $display("byte_range_header_parser regression: fail");
        end
        $finish;
    end

endmodule
